/* hdl/argmax_and_threshold_hit_counter_unit_defines.svh */
// Assertion macros shared by the argmax and threshold hit counter checker.
`ifndef ARGMAX_AND_THRESHOLD_HIT_COUNTER_UNIT_DEFINES_SVH
`define ARGMAX_AND_THRESHOLD_HIT_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked while the disable condition is low.
`define AMTHC_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while the disable condition is low.
`define AMTHC_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/amthc_pkg.sv */
// Types and constants of the argmax and threshold hit counter.
package amthc_pkg;

    localparam int SCORE_WIDTH       = 16;
    localparam int COUNT_FIELD_WIDTH = 24;
    localparam int CLASS_WIDTH       = 2;
    localparam int HITS_WIDTH        = 4;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int MAX_CLASSES       = 4;

    // Operation codes
    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    typedef logic signed [SCORE_WIDTH-1:0] score_t;
    typedef logic [COUNT_FIELD_WIDTH-1:0]  count_field_t;

    typedef struct packed {
        logic [1:0]             operation;
        logic [CLASS_WIDTH-1:0] label;
        logic [CLASS_WIDTH-1:0] read_class;
        score_t                 score_0;
        score_t                 score_1;
        score_t                 score_2;
        score_t                 score_3;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_WIDTH-1:0] predicted_class;
        logic                   no_unique_max;
        logic [HITS_WIDTH-1:0]  threshold_hits;
        count_field_t           max_detect_count;
        count_field_t           max_true_count;
        count_field_t           thr_detect_count;
        count_field_t           thr_true_count;
    } out_item_t;

endpackage

/* hdl/argmax_and_threshold_hit_counter_unit.sv */
// Argmax and threshold hit counter: classify, read and clear per-class counters.
// Path: an accepted item waits in the input register, then in the result register.
// One item per cycle if m_ready allows; compare, scan and counter update fit between items.
// Ready goes low only while both the input and result registers hold a stalled item.
// Reset (aresetn low, synchronous): thresholds and all counters go to zero, both stages empty.
// Configuration writes are always accepted (cfg_ready is tied high).
module argmax_and_threshold_hit_counter_unit #(
    parameter int CLASSES     = 4,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  amthc_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output amthc_pkg::out_item_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amthc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  amthc_pkg::score_t                     cfg_data
);

    typedef logic [COUNT_WIDTH-1:0] count_t;

    logic                 in_valid_reg;
    amthc_pkg::in_item_t  in_data_reg;
    logic                 m_valid_reg;
    amthc_pkg::out_item_t m_data_reg;
    amthc_pkg::out_item_t m_data_next;

    amthc_pkg::score_t thr_reg [CLASSES];
    count_t            max_det_reg  [CLASSES];
    count_t            max_true_reg [CLASSES];
    count_t            thr_det_reg  [CLASSES];
    count_t            thr_true_reg [CLASSES];

    amthc_pkg::score_t                 score [amthc_pkg::MAX_CLASSES];
    amthc_pkg::score_t                 best;
    logic [amthc_pkg::CLASS_WIDTH-1:0] pick;
    logic                              tie;
    logic [CLASSES-1:0]                max_hit;
    logic [CLASSES-1:0]                thr_hit;
    logic                              advance;
    logic                              consume;
    logic                              is_classify;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Handshake: result register frees when empty or taken
    assign advance   = !m_valid_reg || m_ready;
    assign consume   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign is_classify = (in_data_reg.operation == amthc_pkg::OP_CLASSIFY);

    // Hold the accepted item in the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Write thresholds; indexes past the class count are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CLASSES; c++) begin
                thr_reg[c] <= '0;
            end
        end else if (cfg_valid) begin
            for (int c = 0; c < CLASSES; c++) begin
                if (cfg_index == amthc_pkg::CFG_INDEX_WIDTH'(c)) begin
                    thr_reg[c] <= cfg_data;
                end
            end
        end
    end

    // Scan scores in class order; equal to the running maximum marks a tie
    always_comb begin
        score[0] = in_data_reg.score_0;
        score[1] = in_data_reg.score_1;
        score[2] = in_data_reg.score_2;
        score[3] = in_data_reg.score_3;
        best     = score[0];
        pick     = '0;
        tie      = 1'b0;
        for (int c = 1; c < CLASSES; c++) begin
            if (score[c] > best) begin
                best = score[c];
                pick = amthc_pkg::CLASS_WIDTH'(c);
                tie  = 1'b0;
            end else if (score[c] == best) begin
                tie = 1'b1;
            end
        end
    end

    // Per-class hit flags
    always_comb begin
        for (int c = 0; c < CLASSES; c++) begin
            max_hit[c] = !tie && (pick == amthc_pkg::CLASS_WIDTH'(c));
            thr_hit[c] = score[c] > thr_reg[c];
        end
    end

    // Update or clear the saturating counters as the item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CLASSES; c++) begin
                max_det_reg[c]  <= '0;
                max_true_reg[c] <= '0;
                thr_det_reg[c]  <= '0;
                thr_true_reg[c] <= '0;
            end
        end else if (consume) begin
            if (in_data_reg.operation == amthc_pkg::OP_CLEAR) begin
                for (int c = 0; c < CLASSES; c++) begin
                    max_det_reg[c]  <= '0;
                    max_true_reg[c] <= '0;
                    thr_det_reg[c]  <= '0;
                    thr_true_reg[c] <= '0;
                end
            end else if (is_classify) begin
                for (int c = 0; c < CLASSES; c++) begin
                    if (max_hit[c]) begin
                        max_det_reg[c] <= sat_inc(max_det_reg[c]);
                        if (in_data_reg.label == amthc_pkg::CLASS_WIDTH'(c)) begin
                            max_true_reg[c] <= sat_inc(max_true_reg[c]);
                        end
                    end
                    if (thr_hit[c]) begin
                        thr_det_reg[c] <= sat_inc(thr_det_reg[c]);
                        if (in_data_reg.label == amthc_pkg::CLASS_WIDTH'(c)) begin
                            thr_true_reg[c] <= sat_inc(thr_true_reg[c]);
                        end
                    end
                end
            end
        end
    end

    // Build the result item; unused fields stay zero
    always_comb begin
        m_data_next = '0;
        unique case (in_data_reg.operation)
            amthc_pkg::OP_CLASSIFY: begin
                m_data_next.predicted_class = tie ? '0 : pick;
                m_data_next.no_unique_max   = tie;
                for (int c = 0; c < CLASSES; c++) begin
                    m_data_next.threshold_hits[c] = thr_hit[c];
                end
            end
            amthc_pkg::OP_READ: begin
                for (int c = 0; c < CLASSES; c++) begin
                    if (in_data_reg.read_class == amthc_pkg::CLASS_WIDTH'(c)) begin
                        m_data_next.max_detect_count =
                            amthc_pkg::COUNT_FIELD_WIDTH'(max_det_reg[c]);
                        m_data_next.max_true_count =
                            amthc_pkg::COUNT_FIELD_WIDTH'(max_true_reg[c]);
                        m_data_next.thr_detect_count =
                            amthc_pkg::COUNT_FIELD_WIDTH'(thr_det_reg[c]);
                        m_data_next.thr_true_count =
                            amthc_pkg::COUNT_FIELD_WIDTH'(thr_true_reg[c]);
                    end
                end
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* hdl/amthc_checker.sv */
// Port-level checker for the argmax and threshold hit counter, with its bind.
`include "argmax_and_threshold_hit_counter_unit_defines.svh"

module amthc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input amthc_pkg::out_item_t m_data
);

    // Reset empties the result side
    `AMTHC_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_valid, "result valid after reset")

    // Input stalls only when a result is waiting and not taken
    `AMTHC_ASSERT_SAME(a_stall_cause, aclk, !aresetn, !s_ready, m_valid && !m_ready, "input stalled without output backpressure")

    // A stalled result transfer holds its payload
    `AMTHC_ASSERT_NEXT(a_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    // A tie never carries a class
    `AMTHC_ASSERT_SAME(a_tie_class, aclk, !aresetn, m_valid && m_data.no_unique_max, m_data.predicted_class == '0, "tied result carries a class")

    // A classify result with a tie or a threshold hit carries no counts
    `AMTHC_ASSERT_SAME(a_classify_counts, aclk, !aresetn, m_valid && (m_data.no_unique_max || (m_data.threshold_hits != '0)), (m_data.max_detect_count == '0) && (m_data.max_true_count == '0) && (m_data.thr_detect_count == '0) && (m_data.thr_true_count == '0), "classify result carries counts")

endmodule

bind argmax_and_threshold_hit_counter_unit amthc_checker u_amthc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
